### design/ubx_frame_parser_nav_extract_core_macros.svh
`ifndef UBX_FRAME_PARSER_NAV_EXTRACT_CORE_MACROS_SVH
`define UBX_FRAME_PARSER_NAV_EXTRACT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define UBXNAV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Assertion failed in UBX nav extract core.");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define UBXNAV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("Assertion failed in UBX nav extract core.");

`endif

### design/ubxnav_pkg.sv
package ubxnav_pkg;

  localparam int unsigned MaxPayloadDefault = 256;
  localparam int unsigned NumCapture = 14;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0] SyncFirst = 8'hB5;
  localparam logic [7:0] SyncSecond = 8'h62;
  localparam logic [7:0] MatchClassReset = 8'h01;
  localparam logic [7:0] MatchIdReset = 8'h07;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATCH_CLASS = 2'd0,
    CFG_MATCH_ID    = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CHECK_A = 4'd7,
    PH_CHECK_B = 4'd8
  } phase_e;

  typedef struct packed {
    logic [7:0]         fix_type;
    logic [7:0]         sat_count;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] ground_speed;
  } nav_res_t;

  // Payload offset that feeds each capture byte.
  function automatic logic [5:0] capture_offset(input logic [3:0] slot);
    logic [5:0] off;
    if (slot == 4'd0) begin
      off = 6'd20;
    end else if (slot == 4'd1) begin
      off = 6'd23;
    end else if (slot <= 4'd5) begin
      off = 6'(slot) + 6'd26;
    end else if (slot <= 4'd9) begin
      off = 6'(slot) + 6'd18;
    end else begin
      off = 6'(slot) + 6'd50;
    end
    return off;
  endfunction

endpackage

### design/ubxnav_parser.sv
module ubxnav_parser #(
  parameter int unsigned MaxPayload = ubxnav_pkg::MaxPayloadDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [7:0]            byte_i,
  input  logic [7:0]            match_class_i,
  input  logic [7:0]            match_id_i,
  output logic                  res_valid_o,
  output ubxnav_pkg::nav_res_t  res_o
);

  localparam int unsigned IdxW = $clog2(MaxPayload);

  ubxnav_pkg::phase_e phase_q, phase_d;
  logic [7:0]      class_q, class_d;
  logic [7:0]      id_q, id_d;
  logic [15:0]     len_q, len_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_a_q, sum_a_d;
  logic [7:0]      sum_b_q, sum_b_d;
  logic [7:0]      chk_a_q, chk_a_d;
  logic [7:0]      cap_q [ubxnav_pkg::NumCapture];
  logic [7:0]      cap_d [ubxnav_pkg::NumCapture];

  logic [15:0]     len_full;
  logic            len_ok;
  logic [IdxW-1:0] idx_inc;
  logic [7:0]      sum_a_add;
  logic [7:0]      sum_b_add;
  logic            frame_match;

  assign len_full  = {byte_i, len_q[7:0]};
  assign len_ok    = (len_full != 16'd0) && ({1'b0, len_full} < 17'(MaxPayload));
  assign idx_inc   = idx_q + 1'b1;
  assign sum_a_add = sum_a_q + byte_i;
  assign sum_b_add = sum_b_q + sum_a_add;

  always_comb begin
    phase_d = phase_q;
    if (valid_i) begin
      unique case (phase_q)
        ubxnav_pkg::PH_SYNC1: begin
          phase_d = (byte_i == ubxnav_pkg::SyncFirst) ? ubxnav_pkg::PH_SYNC2
                                                      : ubxnav_pkg::PH_SYNC1;
        end
        ubxnav_pkg::PH_SYNC2: begin
          phase_d = (byte_i == ubxnav_pkg::SyncSecond) ? ubxnav_pkg::PH_CLASS
                                                       : ubxnav_pkg::PH_SYNC1;
        end
        ubxnav_pkg::PH_CLASS:  phase_d = ubxnav_pkg::PH_ID;
        ubxnav_pkg::PH_ID:     phase_d = ubxnav_pkg::PH_LEN_LO;
        ubxnav_pkg::PH_LEN_LO: phase_d = ubxnav_pkg::PH_LEN_HI;
        ubxnav_pkg::PH_LEN_HI: begin
          phase_d = len_ok ? ubxnav_pkg::PH_PAYLOAD : ubxnav_pkg::PH_SYNC1;
        end
        ubxnav_pkg::PH_PAYLOAD: begin
          if (16'(idx_inc) >= len_q) begin
            phase_d = ubxnav_pkg::PH_CHECK_A;
          end
        end
        ubxnav_pkg::PH_CHECK_A: phase_d = ubxnav_pkg::PH_CHECK_B;
        ubxnav_pkg::PH_CHECK_B: phase_d = ubxnav_pkg::PH_SYNC1;
        default:                phase_d = ubxnav_pkg::PH_SYNC1;
      endcase
    end
  end

  always_comb begin
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    idx_d   = idx_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    chk_a_d = chk_a_q;
    cap_d   = cap_q;
    if (valid_i) begin
      unique case (phase_q)
        ubxnav_pkg::PH_CLASS: begin
          class_d = byte_i;
          sum_a_d = byte_i;
          sum_b_d = byte_i;
        end
        ubxnav_pkg::PH_ID: begin
          id_d    = byte_i;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
        end
        ubxnav_pkg::PH_LEN_LO: begin
          len_d   = {8'd0, byte_i};
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
        end
        ubxnav_pkg::PH_LEN_HI: begin
          len_d   = len_full;
          idx_d   = '0;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
        end
        ubxnav_pkg::PH_PAYLOAD: begin
          for (int s = 0; s < ubxnav_pkg::NumCapture; s++) begin
            if (idx_q == IdxW'(ubxnav_pkg::capture_offset(4'(s)))) begin
              cap_d[s] = byte_i;
            end
          end
          idx_d   = idx_inc;
          sum_a_d = sum_a_add;
          sum_b_d = sum_b_add;
        end
        ubxnav_pkg::PH_CHECK_A: begin
          chk_a_d = byte_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign frame_match = (phase_q == ubxnav_pkg::PH_CHECK_B) && (chk_a_q == sum_a_q) &&
                       (byte_i == sum_b_q) && (class_q == match_class_i) &&
                       (id_q == match_id_i);

  assign res_valid_o = valid_i && frame_match;

  always_comb begin
    res_o.fix_type     = cap_q[0];
    res_o.sat_count    = cap_q[1];
    res_o.latitude     = {cap_q[5], cap_q[4], cap_q[3], cap_q[2]};
    res_o.longitude    = {cap_q[9], cap_q[8], cap_q[7], cap_q[6]};
    res_o.ground_speed = {cap_q[13], cap_q[12], cap_q[11], cap_q[10]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ubxnav_pkg::PH_SYNC1;
      class_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      chk_a_q <= '0;
      for (int s = 0; s < ubxnav_pkg::NumCapture; s++) begin
        cap_q[s] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      chk_a_q <= chk_a_d;
      cap_q   <= cap_d;
    end
  end

endmodule

### design/ubx_frame_parser_nav_extract_core.sv
// UBX frame parser that takes one serial byte per clock cycle while in_stall_o is low and
// returns the fix type, satellite count, latitude, longitude and ground speed of each
// frame whose checksum is correct and whose class and id equal the match_class and
// match_id registers. Every byte is handled in the cycle it is accepted, so the sustained
// rate is one word per cycle while not stalled. A result is registered into an output
// register backed by one skid register, which lets input words keep flowing while a
// result waits; in_stall_o rises only when both are full. Capture bytes hold their values
// across frames, so a short frame reports fields left by an earlier frame.
module ubx_frame_parser_nav_extract_core #(
  parameter int unsigned MaxPayload = ubxnav_pkg::MaxPayloadDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    fix_type_o,
  output logic [7:0]                    sat_count_o,
  output logic signed [31:0]            latitude_o,
  output logic signed [31:0]            longitude_o,
  output logic signed [31:0]            ground_speed_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ubxnav_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);

  logic                 in_accept;
  logic                 res_valid;
  ubxnav_pkg::nav_res_t res;
  logic                 pop;

  logic [7:0]           match_class_q;
  logic [7:0]           match_id_q;

  logic                 out_valid_q;
  ubxnav_pkg::nav_res_t out_q;
  logic                 skid_valid_q;
  ubxnav_pkg::nav_res_t skid_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign pop         = out_valid_q && !out_stall_i;

  ubxnav_parser #(
    .MaxPayload(MaxPayload)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_accept),
    .byte_i       (rx_byte_i),
    .match_class_i(match_class_q),
    .match_id_i   (match_id_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_class_q <= ubxnav_pkg::MatchClassReset;
      match_id_q    <= ubxnav_pkg::MatchIdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ubxnav_pkg::cfg_reg_e'(cfg_index_i))
        ubxnav_pkg::CFG_MATCH_CLASS: match_class_q <= cfg_data_i;
        ubxnav_pkg::CFG_MATCH_ID:    match_id_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign fix_type_o     = out_q.fix_type;
  assign sat_count_o    = out_q.sat_count;
  assign latitude_o     = out_q.latitude;
  assign longitude_o    = out_q.longitude;
  assign ground_speed_o = out_q.ground_speed;

endmodule

### design/ubxnav_checker.sv
`include "ubx_frame_parser_nav_extract_core_macros.svh"

module ubxnav_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [7:0]                     fix_type_o,
  input  logic [7:0]                     sat_count_o,
  input  logic signed [31:0]             latitude_o,
  input  logic signed [31:0]             longitude_o,
  input  logic signed [31:0]             ground_speed_o
);

  logic [111:0] out_word;

  assign out_word = {fix_type_o, sat_count_o, latitude_o, longitude_o, ground_speed_o};

  `UBXNAV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `UBXNAV_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word))
  `UBXNAV_ASSERT_NOW(a_stall_needs_full_out, in_stall_o, out_valid_o)
  `UBXNAV_ASSERT_NOW(a_stall_rise_on_held_out, $rose(in_stall_o), $past(out_valid_o && out_stall_i))
  `UBXNAV_ASSERT_NOW(a_new_word_from_accept, out_valid_o && !$past(out_valid_o), $past(in_valid_i && !in_stall_o))

endmodule

bind ubx_frame_parser_nav_extract_core ubxnav_checker u_checker (.*);

### test/ubx_frame_parser_nav_extract_core_tb.sv
module ubx_frame_parser_nav_extract_core_tb;
  import ubxnav_pkg::*;

  localparam int unsigned MaxPay = MaxPayloadDefault;
  localparam int LongHold = 300;

  typedef enum logic [1:0] {SHAPE_GOOD, SHAPE_BAD_SUM, SHAPE_BAD_SYNC, SHAPE_HEADER} shape_e;
  typedef enum logic [1:0] {FILL_CONST, FILL_RAMP, FILL_RAND} fill_e;
  typedef enum logic [1:0] {WANT_MODEL, WANT_NONE, WANT_FIX} want_e;

  typedef struct packed {
    shape_e     shape;
    logic [7:0] cls;
    logic [7:0] id;
    logic [15:0] len;
    fill_e      fill;
    logic [7:0] fill_byte;
    want_e      want;
    nav_res_t   fix;
  } frame_row_t;

  localparam nav_res_t FixZero = '0;
  localparam nav_res_t FixOnes = '1;
  localparam nav_res_t FixEighty = {14{8'h80}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] fix_type_o;
  logic [7:0] sat_count_o;
  logic signed [31:0] latitude_o;
  logic signed [31:0] longitude_o;
  logic signed [31:0] ground_speed_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_MATCH_CLASS;
  logic [7:0] cfg_data_i = 8'h00;

  ubx_frame_parser_nav_extract_core #(
    .MaxPayload(MaxPay)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .fix_type_o    (fix_type_o),
    .sat_count_o   (sat_count_o),
    .latitude_o    (latitude_o),
    .longitude_o   (longitude_o),
    .ground_speed_o(ground_speed_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the parser state.
  phase_e      trk_phase = PH_SYNC1;
  logic [7:0]  trk_class = 8'h00;
  logic [7:0]  trk_id = 8'h00;
  logic [15:0] trk_len = 16'h0000;
  logic [15:0] trk_pos = 16'h0000;
  logic [7:0]  trk_sum_a = 8'h00;
  logic [7:0]  trk_sum_b = 8'h00;
  logic [7:0]  trk_chk_a = 8'h00;
  logic [7:0]  trk_capt [14] = '{default: 8'h00};
  logic [7:0]  trk_match_class = MatchClassReset;
  logic [7:0]  trk_match_id = MatchIdReset;

  nav_res_t pending_fixes[$];
  want_e    fix_source = WANT_MODEL;
  nav_res_t typed_fix = '0;
  int       in_idle_max = 6;
  int       out_idle_max = 6;
  int       hold_asks = 0;

  int bytes_sent = 0;
  int frames_sent = 0;
  int fixes_expected = 0;
  int fixes_checked = 0;
  int stall_cycles = 0;
  int mismatches = 0;

  frame_row_t dir_rows[$];

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic track_byte(input logic [7:0] b, output bit fired, output nav_res_t fix);
    int slot;
    fired = 1'b0;
    fix = '0;
    slot = -1;
    if (trk_phase inside {PH_ID, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD}) begin
      trk_sum_a = trk_sum_a + b;
      trk_sum_b = trk_sum_b + trk_sum_a;
    end
    case (trk_phase)
      PH_SYNC2: begin
        trk_phase = (b == SyncSecond) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        trk_class = b;
        trk_sum_a = b;
        trk_sum_b = b;
        trk_phase = PH_ID;
      end
      PH_ID: begin
        trk_id = b;
        trk_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        trk_len = {8'h00, b};
        trk_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        trk_len = {b, trk_len[7:0]};
        trk_pos = 16'h0000;
        trk_phase = (trk_len != 16'h0000 && trk_len < MaxPay) ? PH_PAYLOAD : PH_SYNC1;
      end
      PH_PAYLOAD: begin
        if (trk_pos == 16'd20) begin
          slot = 0;
        end else if (trk_pos == 16'd23) begin
          slot = 1;
        end else if (trk_pos >= 16'd28 && trk_pos <= 16'd31) begin
          slot = 2 + int'(trk_pos) - 28;
        end else if (trk_pos >= 16'd24 && trk_pos <= 16'd27) begin
          slot = 6 + int'(trk_pos) - 24;
        end else if (trk_pos >= 16'd60 && trk_pos <= 16'd63) begin
          slot = 10 + int'(trk_pos) - 60;
        end
        if (slot >= 0) begin
          trk_capt[slot] = b;
        end
        trk_pos = trk_pos + 16'd1;
        if (trk_pos >= trk_len) begin
          trk_phase = PH_CHECK_A;
        end
      end
      PH_CHECK_A: begin
        trk_chk_a = b;
        trk_phase = PH_CHECK_B;
      end
      PH_CHECK_B: begin
        trk_phase = PH_SYNC1;
        if (trk_chk_a == trk_sum_a && b == trk_sum_b &&
            trk_class == trk_match_class && trk_id == trk_match_id) begin
          fired = 1'b1;
          fix.fix_type = trk_capt[0];
          fix.sat_count = trk_capt[1];
          fix.latitude = {trk_capt[5], trk_capt[4], trk_capt[3], trk_capt[2]};
          fix.longitude = {trk_capt[9], trk_capt[8], trk_capt[7], trk_capt[6]};
          fix.ground_speed = {trk_capt[13], trk_capt[12], trk_capt[11], trk_capt[10]};
        end
      end
      default: begin
        trk_phase = (b == SyncFirst) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  endtask

  task automatic check_fix(input nav_res_t got);
    nav_res_t want;
    if (pending_fixes.size() == 0) begin
      flag_mismatch($sformatf("fix %h arrived with none expected", got));
    end else begin
      want = pending_fixes.pop_front();
      fixes_checked++;
      if (got.fix_type !== want.fix_type)
        flag_mismatch($sformatf("fix_type got %h want %h", got.fix_type, want.fix_type));
      if (got.sat_count !== want.sat_count)
        flag_mismatch($sformatf("sat_count got %h want %h", got.sat_count, want.sat_count));
      if (got.latitude !== want.latitude)
        flag_mismatch($sformatf("latitude got %h want %h", got.latitude, want.latitude));
      if (got.longitude !== want.longitude)
        flag_mismatch($sformatf("longitude got %h want %h", got.longitude, want.longitude));
      if (got.ground_speed !== want.ground_speed)
        flag_mismatch($sformatf("ground_speed got %h want %h", got.ground_speed,
                                want.ground_speed));
    end
  endtask

  always @(posedge clk_i) begin
    bit fired;
    nav_res_t fix;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_fix({fix_type_o, sat_count_o, latitude_o, longitude_o, ground_speed_o});
      end
      if (in_valid_i && !in_stall_o) begin
        track_byte(rx_byte_i, fired, fix);
        if (fired && fix_source != WANT_NONE) begin
          pending_fixes.push_back(fix_source == WANT_FIX ? typed_fix : fix);
          fixes_expected++;
        end
      end
      if (in_valid_i && in_stall_o) begin
        stall_cycles++;
      end
    end
  end

  // The receiver stalls for a random stretch before each word, or for one long stretch on request.
  initial begin : fix_sink
    int n;
    int holds_done;
    holds_done = 0;
    wait (rst_ni);
    forever begin
      if (hold_asks != holds_done) begin
        holds_done++;
        n = LongHold;
      end else begin
        n = $urandom_range(0, out_idle_max);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_row_t r);
    logic [7:0] body[$];
    logic [7:0] sa;
    logic [7:0] sb;
    fix_source <= r.want;
    typed_fix <= r.fix;
    body = '{r.cls, r.id, r.len[7:0], r.len[15:8]};
    if (r.shape == SHAPE_HEADER) begin
      body.push_back(r.fill_byte);
      body.push_back(r.fill_byte);
    end else begin
      for (int k = 0; k < int'(r.len); k++) begin
        case (r.fill)
          FILL_CONST: body.push_back(r.fill_byte);
          FILL_RAMP:  body.push_back(8'(k));
          default:    body.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      sa = 8'h00;
      sb = 8'h00;
      foreach (body[k]) begin
        sa = sa + body[k];
        sb = sb + sa;
      end
      if (r.shape == SHAPE_BAD_SUM) begin
        if ($urandom_range(0, 1) == 0) begin
          sa = sa ^ (8'd1 << $urandom_range(0, 7));
        end else begin
          sb = sb ^ (8'd1 << $urandom_range(0, 7));
        end
      end
      body.push_back(sa);
      body.push_back(sb);
    end
    send_byte(SyncFirst);
    if (r.shape == SHAPE_BAD_SYNC) begin
      send_byte(SyncFirst);
    end
    send_byte(SyncSecond);
    foreach (body[k]) begin
      send_byte(body[k]);
    end
    frames_sent++;
  endtask

  task automatic wait_idle;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_fixes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MATCH_CLASS) begin
      trk_match_class = val;
    end else begin
      trk_match_id = val;
    end
  endtask

  task automatic apply_match(input logic [7:0] cls, input logic [7:0] id);
    wait_idle();
    write_reg(CFG_MATCH_CLASS, cls);
    write_reg(CFG_MATCH_ID, id);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed frames with random content, mixed with broken frames and noise.
  task automatic random_traffic(input int nbytes);
    frame_row_t r;
    int start;
    int d;
    start = bytes_sent;
    while (bytes_sent < start + nbytes) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
      r = '0;
      r.want = WANT_MODEL;
      r.fill = FILL_RAND;
      r.fill_byte = 8'($urandom_range(0, 255));
      r.cls = ($urandom_range(0, 9) < 7) ? trk_match_class : 8'($urandom_range(0, 255));
      r.id = ($urandom_range(0, 9) < 7) ? trk_match_id : 8'($urandom_range(0, 255));
      d = $urandom_range(0, 19);
      if (d < 8) begin
        r.len = 16'($urandom_range(1, 30));
      end else if (d < 16) begin
        r.len = 16'($urandom_range(31, 70));
      end else if (d < 18) begin
        r.len = 16'($urandom_range(71, MaxPay - 1));
      end else begin
        r.len = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(MaxPay, 65535));
      end
      d = $urandom_range(0, 19);
      if (r.len == 16'd0 || r.len >= MaxPay) begin
        r.shape = SHAPE_HEADER;
      end else if (d < 2) begin
        r.shape = SHAPE_BAD_SUM;
      end else if (d == 2) begin
        r.shape = SHAPE_BAD_SYNC;
      end else begin
        r.shape = SHAPE_GOOD;
      end
      send_frame(r);
    end
  endtask

  initial begin
    #2000000;
    $display("ubx_frame_parser_nav_extract_core_tb NOT OK");
    $finish;
  end

  initial begin : main_flow
    frame_row_t r;
    dir_rows = '{
      '{SHAPE_GOOD,     MatchClassReset, MatchIdReset, 16'd1,     FILL_CONST, 8'h00,
        WANT_FIX,   FixZero},
      '{SHAPE_BAD_SYNC, MatchClassReset, MatchIdReset, 16'd1,     FILL_CONST, 8'h00,
        WANT_NONE,  FixZero},
      '{SHAPE_HEADER,   MatchClassReset, MatchIdReset, 16'd0,     FILL_CONST, 8'h00,
        WANT_NONE,  FixZero},
      '{SHAPE_HEADER,   MatchClassReset, MatchIdReset, 16'h0100,  FILL_CONST, 8'h00,
        WANT_NONE,  FixZero},
      '{SHAPE_HEADER,   MatchClassReset, MatchIdReset, 16'hFFFF,  FILL_CONST, 8'h00,
        WANT_NONE,  FixZero},
      '{SHAPE_GOOD,     MatchClassReset, MatchIdReset, 16'd64,    FILL_CONST, 8'hFF,
        WANT_FIX,   FixOnes},
      '{SHAPE_GOOD,     MatchClassReset, MatchIdReset, 16'd64,    FILL_CONST, 8'h00,
        WANT_FIX,   FixZero},
      '{SHAPE_GOOD,     MatchClassReset, MatchIdReset, 16'd64,    FILL_CONST, 8'h80,
        WANT_FIX,   FixEighty},
      '{SHAPE_BAD_SUM,  MatchClassReset, MatchIdReset, 16'd64,    FILL_CONST, 8'h7F,
        WANT_NONE,  FixZero},
      '{SHAPE_GOOD,     MatchClassReset, MatchIdReset, 16'd21,    FILL_RAMP,  8'h00,
        WANT_MODEL, FixZero},
      '{SHAPE_GOOD,     8'h02,           MatchIdReset, 16'd64,    FILL_RAMP,  8'h00,
        WANT_NONE,  FixZero},
      '{SHAPE_GOOD,     MatchClassReset, 8'h08,        16'd30,    FILL_CONST, 8'hFF,
        WANT_NONE,  FixZero},
      '{SHAPE_GOOD,     MatchClassReset, MatchIdReset, 16'd1,     FILL_CONST, 8'h00,
        WANT_MODEL, FixZero},
      '{SHAPE_GOOD,     MatchClassReset, MatchIdReset, 16'd24,    FILL_RAND,  8'h00,
        WANT_MODEL, FixZero},
      '{SHAPE_GOOD,     MatchClassReset, MatchIdReset, 16'd62,    FILL_RAND,  8'h00,
        WANT_MODEL, FixZero},
      '{SHAPE_GOOD,     MatchClassReset, MatchIdReset, 16'd255,   FILL_RAND,  8'h00,
        WANT_MODEL, FixZero},
      '{SHAPE_GOOD,     MatchClassReset, MatchIdReset, 16'd64,    FILL_RAND,  8'h00,
        WANT_MODEL, FixZero}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      send_frame(dir_rows[k]);
    end

    in_idle_max = 0;
    out_idle_max = 0;
    apply_match(8'h00, 8'h00);
    random_traffic(200);

    in_idle_max = 6;
    apply_match(8'hFF, 8'hFF);
    random_traffic(200);

    in_idle_max = 0;
    out_idle_max = 6;
    apply_match(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_traffic(200);

    // Back-to-back short frames against a long output stall fill the block.
    out_idle_max = 0;
    apply_match(MatchClassReset, MatchIdReset);
    hold_asks <= hold_asks + 1;
    repeat (30) begin
      r = '0;
      r.shape = SHAPE_GOOD;
      r.cls = MatchClassReset;
      r.id = MatchIdReset;
      r.len = 16'($urandom_range(1, 8));
      r.fill = FILL_RAND;
      r.want = WANT_MODEL;
      send_frame(r);
    end

    in_idle_max = 6;
    out_idle_max = 6;
    random_traffic(200);
    while (fixes_expected < 40) begin
      random_traffic(100);
    end

    wait_idle();
    $display("Sent %0d bytes in %0d frames under four match settings; %0d fixes checked.",
             bytes_sent, frames_sent, fixes_checked);
    $display("Input held off for %0d cycles while the output was stalled.", stall_cycles);
    if (mismatches == 0) begin
      $display("ubx_frame_parser_nav_extract_core_tb OK");
    end else begin
      $display("ubx_frame_parser_nav_extract_core_tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/ubxnav_pkg.sv
design/ubxnav_parser.sv
design/ubx_frame_parser_nav_extract_core.sv
design/ubxnav_checker.sv
test/ubx_frame_parser_nav_extract_core_tb.sv
